[sv/bss_pkg.sv]
// shared types, constants and bit-search functions for the bitmap sorted set
package bss_pkg;

    localparam int KEY_W     = 12;
    localparam int CNT_W     = 13;
    localparam int LEAF_BITS = 64;
    localparam int LEAF_IW   = 6;
    localparam int UNIVERSE_DEF = 4096;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_MEMBER  = 3'd2,
        OP_SUCC    = 3'd3,
        OP_PRED    = 3'd4,
        OP_EXTRACT = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] found_value;
        logic             found_valid;
        logic [KEY_W-1:0] smallest_key;
        logic [KEY_W-1:0] largest_key;
        logic [CNT_W-1:0] member_count;
    } out_t;

    typedef struct packed {
        logic start;
        logic exec;
        logic srch;
        logic fetch;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic exec_search;
        logic srch_fetch;
        logic out_busy;
    } stat_t;

    // position of the lowest set bit, 0 for an empty word
    function automatic logic [LEAF_IW-1:0] low_bit(input logic [LEAF_BITS-1:0] w);
        logic [LEAF_BITS-1:0] iso;
        logic [LEAF_IW-1:0]   idx;
        iso = w & (~w + 64'd1);
        idx = '0;
        for (int i = 0; i < LEAF_BITS; i++) begin
            if (iso[i]) begin
                idx = idx | LEAF_IW'(i);
            end
        end
        return idx;
    endfunction

    // position of the highest set bit, 63 for an empty word
    function automatic logic [LEAF_IW-1:0] high_bit(input logic [LEAF_BITS-1:0] w);
        logic [LEAF_BITS-1:0] rev;
        for (int i = 0; i < LEAF_BITS; i++) begin
            rev[i] = w[LEAF_BITS-1-i];
        end
        return ~low_bit(rev);
    endfunction

endpackage

[sv/bss_ctrl.sv]
// controller state machine sequencing one transaction through the datapath
module bss_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bss_pkg::stat_t stat,
    output bss_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SRCH,
        ST_FETCH,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cmd.start = s_valid && (state_reg == ST_IDLE);
    assign cmd.exec  = (state_reg == ST_EXEC);
    assign cmd.srch  = (state_reg == ST_SRCH);
    assign cmd.fetch = (state_reg == ST_FETCH);
    assign cmd.load  = (state_reg == ST_DONE) && !stat.out_busy;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_EXEC;
            ST_EXEC:  state_next = stat.exec_search ? ST_SRCH : ST_DONE;
            ST_SRCH:  state_next = stat.srch_fetch ? ST_FETCH : ST_DONE;
            ST_FETCH: state_next = ST_DONE;
            ST_DONE:  if (!stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/bss_dp.sv]
// datapath: leaf word memory, summary bitmap, extremes, count and result register
module bss_dp #(
    parameter int UNIVERSE = bss_pkg::UNIVERSE_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bss_pkg::in_t   s_data,
    input  bss_pkg::cmd_t  cmd,
    output bss_pkg::stat_t stat,
    output logic           m_valid,
    input  logic           m_ready,
    output bss_pkg::out_t  m_data
);

    localparam int NCL = UNIVERSE / bss_pkg::LEAF_BITS;
    localparam int CW  = (NCL > 1) ? $clog2(NCL) : 1;
    localparam int KW  = bss_pkg::KEY_W;
    localparam int LW  = bss_pkg::LEAF_BITS;
    localparam int IW  = bss_pkg::LEAF_IW;

    typedef enum logic [1:0] {
        TGT_FOUND,
        TGT_MIN,
        TGT_MAX
    } tgt_t;

    logic [LW-1:0] mem [2**CW];
    logic [LW-1:0] rdata_reg;
    logic [CW-1:0] rd_addr;
    logic          sbit_reg;

    logic [2:0]              kind_reg;
    logic [KW-1:0]           key_reg;
    logic [NCL-1:0]          sum_reg, sum_next;
    logic [KW-1:0]           min_reg, min_next, max_reg, max_next;
    logic [bss_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [LW-1:0]           w_reg, w_next;
    logic                    up_reg, up_next;
    tgt_t                    tgt_reg, tgt_next;
    logic [IW-1:0]           fc_reg, fc_next;
    logic                    ok_reg, ok_next, fv_reg, fv_next;
    logic [KW-1:0]           fval_reg, fval_next;
    logic                    m_valid_reg;
    bss_pkg::out_t           m_data_reg;

    logic          we;
    logic [LW-1:0] wdata;
    logic [KW-1:0] key_eff;
    logic [LW-1:0] word, sum_ext, sum_mod, bitm, new_word, wm, sm;
    logic [IW-1:0] jpos, cpos, enc_w, enc_s, enc_f;
    logic          hit, inr, res_en;
    logic [KW-1:0] res;

    assign key_eff = (s_data.kind == bss_pkg::OP_EXTRACT) ? min_reg : s_data.key;
    assign sum_ext = LW'(sum_reg);
    assign jpos    = key_reg[IW-1:0];
    assign cpos    = key_reg[KW-1:IW];
    assign bitm    = LW'(1) << jpos;
    assign word    = rdata_reg & {LW{sbit_reg}};
    assign hit     = word[jpos];
    assign inr     = ({1'b0, key_reg} < (KW+1)'(UNIVERSE));
    assign new_word = word & ~bitm;

    // search masks strictly above or below the key
    assign wm = w_reg & (up_reg ? ~((LW'(2) << jpos) - LW'(1)) : ((LW'(1) << jpos) - LW'(1)));
    assign sm = sum_ext & (up_reg ? ~((LW'(2) << cpos) - LW'(1))
                                  : ((LW'(1) << cpos) - LW'(1)));
    assign enc_w = up_reg ? bss_pkg::low_bit(wm) : bss_pkg::high_bit(wm);
    assign enc_s = up_reg ? bss_pkg::low_bit(sm) : bss_pkg::high_bit(sm);
    assign enc_f = up_reg ? bss_pkg::low_bit(rdata_reg) : bss_pkg::high_bit(rdata_reg);

    always_comb begin
        if (cmd.srch) begin
            rd_addr = enc_s[CW-1:0];
        end else begin
            rd_addr = key_eff[IW +: CW];
        end
    end

    always_comb begin
        sum_mod   = sum_ext;
        min_next  = min_reg;
        max_next  = max_reg;
        cnt_next  = cnt_reg;
        w_next    = w_reg;
        up_next   = up_reg;
        tgt_next  = tgt_reg;
        fc_next   = fc_reg;
        ok_next   = ok_reg;
        fv_next   = fv_reg;
        fval_next = fval_reg;
        we        = 1'b0;
        wdata     = word | bitm;
        res_en    = 1'b0;
        res       = '0;
        stat.exec_search = 1'b0;
        stat.srch_fetch  = 1'b0;
        stat.out_busy    = m_valid_reg && !m_ready;

        if (cmd.start) begin
            ok_next   = 1'b0;
            fv_next   = 1'b0;
            fval_next = '0;
        end

        if (cmd.exec) begin
            case (kind_reg)
                bss_pkg::OP_INSERT: begin
                    if (inr && !hit) begin
                        ok_next = 1'b1;
                        we      = 1'b1;
                        wdata   = word | bitm;
                        sum_mod = sum_ext | (LW'(1) << cpos);
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == '0) begin
                            min_next = key_reg;
                            max_next = key_reg;
                        end else begin
                            if (key_reg < min_reg) min_next = key_reg;
                            if (key_reg > max_reg) max_next = key_reg;
                        end
                    end
                end
                bss_pkg::OP_REMOVE, bss_pkg::OP_EXTRACT: begin
                    if (inr && hit) begin
                        ok_next = 1'b1;
                        if (kind_reg == bss_pkg::OP_EXTRACT) begin
                            fv_next   = 1'b1;
                            fval_next = key_reg;
                        end
                        we    = 1'b1;
                        wdata = new_word;
                        if (new_word == '0) sum_mod = sum_ext & ~(LW'(1) << cpos);
                        cnt_next = cnt_reg - 1'b1;
                        w_next   = new_word;
                        if (cnt_reg == bss_pkg::CNT_W'(1)) begin
                            min_next = '0;
                            max_next = '0;
                        end else if (key_reg == min_reg) begin
                            up_next  = 1'b1;
                            tgt_next = TGT_MIN;
                            stat.exec_search = 1'b1;
                        end else if (key_reg == max_reg) begin
                            up_next  = 1'b0;
                            tgt_next = TGT_MAX;
                            stat.exec_search = 1'b1;
                        end
                    end
                end
                bss_pkg::OP_MEMBER: begin
                    ok_next = inr && hit;
                end
                bss_pkg::OP_SUCC, bss_pkg::OP_PRED: begin
                    if (inr) begin
                        w_next   = word;
                        up_next  = (kind_reg == bss_pkg::OP_SUCC);
                        tgt_next = TGT_FOUND;
                        stat.exec_search = 1'b1;
                    end else if (kind_reg == bss_pkg::OP_PRED && cnt_reg != '0) begin
                        fv_next   = 1'b1;
                        fval_next = max_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.srch) begin
            if (wm != '0) begin
                res_en = 1'b1;
                res    = {cpos, enc_w};
            end else if (sm != '0) begin
                fc_next = enc_s;
                stat.srch_fetch = 1'b1;
            end
        end

        if (cmd.fetch) begin
            res_en = 1'b1;
            res    = {fc_reg, enc_f};
        end

        if (res_en) begin
            case (tgt_reg)
                TGT_MIN:   min_next = res;
                TGT_MAX:   max_next = res;
                default: begin
                    fv_next   = 1'b1;
                    fval_next = res;
                end
            endcase
        end

        sum_next = sum_mod[NCL-1:0];
    end

    // leaf memory; summary bit qualifies the read so no clearing pass is needed
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[cpos[CW-1:0]] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
        sbit_reg  <= sum_ext[IW'(rd_addr)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
            cnt_reg <= cnt_next;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg <= s_data.kind;
            key_reg  <= key_eff;
        end
        w_reg    <= w_next;
        up_reg   <= up_next;
        tgt_reg  <= tgt_next;
        fc_reg   <= fc_next;
        ok_reg   <= ok_next;
        fv_reg   <= fv_next;
        fval_reg <= fval_next;
        if (cmd.load) begin
            m_data_reg.ok           <= ok_reg;
            m_data_reg.found_value  <= fval_reg;
            m_data_reg.found_valid  <= fv_reg;
            m_data_reg.smallest_key <= min_reg;
            m_data_reg.largest_key  <= max_reg;
            m_data_reg.member_count <= cnt_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/bitmap_sorted_set_core.sv]
// Sorted integer set over 0..UNIVERSE-1 kept as a summary bitmap over 64-bit leaf
// words. One transaction (insert, remove, member, strict successor, strict
// predecessor, extract minimum) gives one result with the set's minimum, maximum
// and count after it. Each transaction is handled alone: insert, member and the
// out-of-range cases pass through the states EXEC and DONE, a search that ends in
// the key's own leaf word through EXEC, SRCH and DONE, and one that has to read a
// second leaf word through the single read port of the leaf memory through EXEC,
// SRCH, FETCH and DONE. The result is loaded in DONE once the previous result no
// longer waits for m_ready, and the next transaction is accepted back in IDLE. A
// remove or extract that takes away the minimum or maximum runs such a search to
// find the new extreme. The set is empty right after reset, with no clearing
// pass, since the summary bitmap qualifies every leaf read.
module bitmap_sorted_set_core #(
    parameter int UNIVERSE = bss_pkg::UNIVERSE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bss_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bss_pkg::out_t m_data
);

    bss_pkg::cmd_t  cmd;
    bss_pkg::stat_t stat;

    bss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bss_dp #(
        .UNIVERSE (UNIVERSE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
